// ===== rtl/base64_stream_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Base64 stream encoder
// Clocked implication checks, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define B64SE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64se: same-cycle check failed");

// Next-cycle implication.
`define B64SE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64se: next-cycle check failed");

`endif

// ===== rtl/b64se_pkg.sv =====
// ----------------------------------------------------------------------------
// b64se_pkg
// Shared types, character codes and the Base64 alphabet lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64se_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic ESCAPE_PLUS_RESET = 1'b1;

  localparam logic [7:0] CHAR_PAD  = 8'h3D; // '='
  localparam logic [7:0] CHAR_PLUS = 8'h2B; // '+'
  localparam logic [7:0] CHAR_PCT  = 8'h25; // '%'
  localparam logic [7:0] CHAR_TWO  = 8'h32; // '2'
  localparam logic [7:0] CHAR_BIG_B = 8'h42; // 'B'

  // One group to encode: three bytes (zero padded) and how many of the
  // four output slots carry alphabet characters; the rest are pads.
  typedef struct packed {
    logic [23:0] group;
    logic [2:0]  nchar;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v inside {[6'd0:6'd25]}) begin
      c = 8'h41 + {2'b00, v};
    end else if (v inside {[6'd26:6'd51]}) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v inside {[6'd52:6'd61]}) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== rtl/b64se_front.sv =====
// ----------------------------------------------------------------------------
// b64se_front
// Accepts raw bytes, gathers them into groups of three and issues a job
// whenever a group completes or the stream closes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64se_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  input  b64se_pkg::queue_status_t q_status,
  output logic                    push,
  output b64se_pkg::job_t         job
);
  import b64se_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic [1:0] cnt;
  logic       accept;
  logic       gen;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  // a stray count of three behaves as two
  assign cnt      = count[1] ? 2'd2 : count;

  always_comb begin
    gen        = 1'b0;
    job.group  = {pend0, pend1, data_byte};
    job.nchar  = 3'd4;
    count_next = count;
    if (cnt == 2'd2) begin
      gen        = 1'b1;
      count_next = 2'd0;
    end else begin
      count_next = cnt + 2'd1;
      if (last_byte) begin
        gen = 1'b1;
        if (cnt == 2'd0) begin
          job.group = {data_byte, 16'h0000};
          job.nchar = 3'd2;
        end else begin
          job.group = {pend0, data_byte, 8'h00};
          job.nchar = 3'd3;
        end
      end
    end
    if (last_byte) begin
      count_next = 2'd0;
    end
  end

  assign push = accept && gen;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cnt == 2'd0) begin
      pend0 <= data_byte;
    end
    if (accept && cnt == 2'd1) begin
      pend1 <= data_byte;
    end
  end

endmodule

// ===== rtl/b64se_queue.sv =====
// ----------------------------------------------------------------------------
// b64se_queue
// Short job queue between the byte gatherer and the character sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64se_queue #(
  parameter int unsigned DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  b64se_pkg::job_t          push_job,
  input  logic                     pop,
  output b64se_pkg::job_t          head_job,
  output b64se_pkg::queue_status_t status
);
  import b64se_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] fill;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_job     = entries[head];
  assign status.valid = (fill != '0);
  assign status.full  = (fill == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= wrap_inc(tail);
      end
      if (pop) begin
        head <= wrap_inc(head);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_job;
    end
  end

endmodule

// ===== rtl/b64se_back.sv =====
// ----------------------------------------------------------------------------
// b64se_back
// Walks the four slots of the head job, with the optional percent escape of
// plus, into the output register: one character a cycle when not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64se_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     escape_plus,
  input  b64se_pkg::job_t          head_job,
  input  b64se_pkg::queue_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_char,
  output logic                     last_char
);
  import b64se_pkg::*;

  logic [1:0] slot;
  logic [1:0] sub;
  logic [5:0] sext;
  logic [7:0] base_char;
  logic [7:0] emit_char;
  logic       esc;
  logic       slot_done;
  logic       load;

  always_comb begin
    case (slot)
      2'd0:    sext = head_job.group[23:18];
      2'd1:    sext = head_job.group[17:12];
      2'd2:    sext = head_job.group[11:6];
      2'd3:    sext = head_job.group[5:0];
      default: sext = head_job.group[5:0];
    endcase
  end

  assign base_char = ({1'b0, slot} >= head_job.nchar) ? CHAR_PAD : b64_char(sext);
  assign esc       = escape_plus && (base_char == CHAR_PLUS);
  assign slot_done = !esc || (sub == 2'd2);

  always_comb begin
    if (!esc) begin
      emit_char = base_char;
    end else begin
      case (sub)
        2'd0:    emit_char = CHAR_PCT;
        2'd1:    emit_char = CHAR_TWO;
        default: emit_char = CHAR_BIG_B;
      endcase
    end
  end

  assign load = q_status.valid && (!out_valid || out_ready);
  assign pop  = load && slot_done && (slot == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= 2'd0;
      sub       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (slot_done) begin
          sub  <= 2'd0;
          slot <= slot + 2'd1;
        end else begin
          sub <= sub + 2'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= emit_char;
      last_char <= slot_done && (slot == 2'd3);
    end
  end

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder with optional percent escape of plus.
// ----------------------------------------------------------------------------
// Input channel: one raw byte per item (data_byte, last_byte) on
// in_valid/in_ready. Output channel: one ASCII character per item
// (out_char, last_char) on out_valid/out_ready; last_char closes the
// characters caused by one input byte.
// Every third byte, and any byte flagged last_byte, releases a group of
// four characters ('=' pads on a short final group). With escape_plus
// set, each '+' leaves as the three characters '%', '2', 'B'.
// A group's job passes through the job queue and then the output
// register before its first character is valid.
// The output sequencer gives one character per cycle while a job waits
// and the receiver takes them; bytes that only join a group are taken
// whenever the queue is not full.
// A two-entry job queue lets bytes keep arriving while the receiver
// stalls; in_ready drops only when the queue is full.
// Reset clears the open group, the queue and the output register, and
// sets escape_plus to 1. cfg_we writes escape_plus at the next edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_char
);
  import b64se_pkg::*;

  `include "base64_stream_encoder_assert.svh"

  logic          escape_plus;
  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head_job;
  queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_plus <= ESCAPE_PLUS_RESET;
    end else if (cfg_we) begin
      escape_plus <= cfg_wdata;
    end
  end

  b64se_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_status  (q_status),
    .push      (push),
    .job       (push_job)
  );

  b64se_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  b64se_back u_back (
    .clk         (clk),
    .rst         (rst),
    .escape_plus (escape_plus),
    .head_job    (head_job),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_char   (last_char)
  );

  // a full queue must hold off new bytes
  `B64SE_ASSERT_NOW(a_no_overflow, clk, rst, q_status.full, !in_ready && !push)
  // a new group never opens with a pad
  `B64SE_ASSERT_NEXT(a_group_start, clk, rst, out_valid && out_ready && last_char,
    !out_valid || out_char != CHAR_PAD)
  // pads run to the end of their group without a gap
  `B64SE_ASSERT_NEXT(a_pad_run, clk, rst,
    out_valid && out_ready && out_char == CHAR_PAD && !last_char,
    out_valid && out_char == CHAR_PAD)

endmodule

// ===== sim/tb_base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Self-checking bench for the streaming Base64 encoder.
// A short table of directed bytes (extremes, plus escaping, short final
// groups, a full final group) is followed by random byte streams under
// three idle patterns and both escape settings. Every character is compared
// against an in-bench encoder that tracks the open group, or a row's text.
// ----------------------------------------------------------------------------

module tb_base64_stream_encoder;
  import b64se_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic [1:0] {CFG_KEEP, CFG_PLUS_RAW, CFG_PLUS_ESCAPED} cfg_act_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  typedef struct packed {
    cfg_act_t    act;
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [95:0] txt;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       last_char;

  // encoder state mirrored by the bench
  logic       plus_escaped = 1'b1;
  logic [7:0] grp_byte [2];
  logic [1:0] grp_count;

  enc_char_t  exp_chars [$];
  enc_char_t  want;
  stim_row_t  stim_tab [0:22];

  int  send_idle_pct = 25;
  int  recv_idle_pct = 58;
  bit  hold_req = 1'b0;
  int  err_cnt = 0;
  int  n_bytes = 0;
  int  n_streams = 0;
  int  n_chars = 0;
  int  n_escapes = 0;

  base64_stream_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last_char (last_char)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Append one expected character to the end of the queue.
  function automatic void queue_char(input logic [7:0] c, input logic l);
    enc_char_t e;
    e.ch   = c;
    e.last = l;
    exp_chars.insert(exp_chars.size(), e);
  endfunction

  function automatic void push_char(input logic [7:0] c);
    if (c == CHAR_PLUS && plus_escaped) begin
      queue_char(CHAR_PCT, 1'b0);
      queue_char(CHAR_TWO, 1'b0);
      queue_char(CHAR_BIG_B, 1'b0);
      n_escapes++;
    end else begin
      queue_char(c, 1'b0);
    end
  endfunction

  // Encode one byte; return how many characters it releases.
  function automatic int encode_byte(input logic [7:0] d, input logic l);
    logic [23:0] grp;
    int          n_sym;
    int          first;
    int          k;
    first = exp_chars.size();
    n_sym = 0;
    if (grp_count == 2'd2) begin
      grp = {grp_byte[0], grp_byte[1], d};
      n_sym = 4;
      grp_count = 2'd0;
    end else begin
      grp_byte[grp_count] = d;
      grp_count = grp_count + 2'd1;
      if (l) begin
        grp = {grp_byte[0], (grp_count == 2'd2) ? grp_byte[1] : 8'h00, 8'h00};
        n_sym = grp_count + 1;
      end
    end
    for (k = 0; k < n_sym; k++)
      push_char(ALPHABET[8*(63 - grp[23-6*k -: 6]) +: 8]);
    if (l && n_sym < 4) begin
      for (k = n_sym; k < 4; k++)
        push_char(CHAR_PAD);
    end
    if (l) begin
      grp_count = 2'd0;
      grp_byte[0] = 8'h00;
      grp_byte[1] = 8'h00;
    end
    if (exp_chars.size() > first)
      exp_chars[$].last = 1'b1;
    return exp_chars.size() - first;
  endfunction

  // Offer one item and hold it until taken; valid stays high on return.
  task automatic send_item(input logic [7:0] d, input logic l, output int n_new);
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    n_new = encode_byte(d, l);
    n_bytes++;
    if (l)
      n_streams++;
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (exp_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_escape(input logic v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    plus_escaped = v;
  endtask

  // Bias towards bytes that put sextet 62 or 63 in any slot.
  function automatic logic [7:0] pick_byte();
    logic [7:0] r;
    r = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: return {6'h3E, r[1:0]};
      1: return {r[1:0], 6'h3E};
      2: return 8'hEF;
      3: return 8'hFF;
      4: return 8'h00;
      default: return r;
    endcase
  endfunction

  task automatic run_streams(input int target);
    int sent;
    int len;
    int i;
    int n_new;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 7);
      for (i = 0; i < len; i++) begin
        send_item(pick_byte(), i == len - 1, n_new);
        sender_gap();
      end
      sent += len;
    end
  endtask

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_chars.size() == 0) begin
        $error("unexpected character: out_char %02h, last_char %0b", out_char, last_char);
        err_cnt++;
      end else begin
        want = exp_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %02h, got %02h", want.ch, out_char);
          err_cnt++;
        end
        if (last_char !== want.last) begin
          $error("last_char: expected %0b, got %0b", want.last, last_char);
          err_cnt++;
        end
        n_chars++;
      end
    end
  end

  initial begin
    int r;
    int k;
    int n_new;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    grp_byte[0] = 8'h00;
    grp_byte[1] = 8'h00;
    grp_count   = 2'd0;

    stim_tab = '{
      '{CFG_KEEP,     8'h00, 1'b1, 1'b1, "AA=="},
      '{CFG_KEEP,     8'hFF, 1'b1, 1'b1, "/w=="},
      '{CFG_KEEP,     8'hFF, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hFF, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hFF, 1'b0, 1'b1, "////"},
      '{CFG_KEEP,     8'hFB, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hEF, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hBE, 1'b0, 1'b1, "%2B%2B%2B%2B"},
      '{CFG_KEEP,     8'hFB, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hF0, 1'b1, 1'b1, "%2B/A="},
      '{CFG_KEEP,     8'h4D, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'h61, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'h6E, 1'b1, 1'b1, "TWFu"},
      '{CFG_KEEP,     8'hF8, 1'b1, 1'b1, "%2BA=="},
      '{CFG_KEEP,     8'h12, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'h34, 1'b1, 1'b0, ""},
      '{CFG_PLUS_RAW, 8'hA5, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'h5A, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hC3, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hFB, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hEF, 1'b0, 1'b0, ""},
      '{CFG_KEEP,     8'hBE, 1'b0, 1'b1, "++++"},
      '{CFG_KEEP,     8'hF8, 1'b1, 1'b1, "+A=="}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, escape at its reset value until told otherwise
    for (r = 0; r < 23; r++) begin
      if (stim_tab[r].act != CFG_KEEP)
        write_escape(stim_tab[r].act == CFG_PLUS_ESCAPED);
      send_item(stim_tab[r].data, stim_tab[r].last, n_new);
      if (stim_tab[r].typed) begin
        // swap the computed characters for the literal ones
        repeat (n_new) void'(exp_chars.pop_back());
        for (k = 11; k >= 0; k--) begin
          if (stim_tab[r].txt[8*k +: 8] != 8'h00)
            queue_char(stim_tab[r].txt[8*k +: 8], 1'b0);
        end
        exp_chars[$].last = 1'b1;
      end
      sender_gap();
    end

    write_escape(1'b1);
    run_streams(80);

    send_idle_pct = 58;
    recv_idle_pct = 25;
    write_escape(1'b0);
    run_streams(80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_escape(1'b1);
    // stall the receiver while bytes keep coming, so the job queue fills
    hold_req = 1'b1;
    run_streams(30);
    run_streams(50);

    drain_results();

    $display("Encoded %0d bytes in %0d streams, checked %0d characters.",
             n_bytes, n_streams, n_chars);
    $display("Escaped %0d plus signs; both escape settings, three idle patterns.",
             n_escapes);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
